// ===== sv/lz77d_pkg.sv =====
`timescale 1ns / 1ps

package lz77d_pkg;

    // History window: the distance field is 12 bits, so the window is 4 KiB.
    localparam int ADDR_W       = 12;
    localparam int WINDOW_DEPTH = 1 << ADDR_W;

    // Longest copy a token can ask for, and the counter that holds it.
    localparam int MAX_COPY  = 18;
    localparam int COPY_W    = $clog2(MAX_COPY + 1);
    localparam int LEN_BIAS  = 3;
    localparam int SIZE_W    = 24;
    localparam int FLAG_CNT  = 8;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_FLAG     = 3'd1,
        PH_LITERAL  = 3'd2,
        PH_TOKEN_HI = 3'd3,
        PH_TOKEN_LO = 3'd4,
        PH_DRAIN    = 3'd5,
        PH_COPY     = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_TRUNC = 2'd1,
        ST_DIST  = 2'd2
    } t_status;

endpackage

// ===== sv/lz77_type10_decompressor.sv =====
`timescale 1ns / 1ps

// LZ77 type 0x10 decompressor.
// The slave stream carries the compressed stream one byte per word, header
// included; tlast marks the final byte of a stream. The master stream returns
// one word per decompressed byte, with tuser giving the status (data,
// truncated input or invalid distance) and tlast marking the final word of
// the stream (its last byte, the done word of an empty stream, or an error).
// A literal, a done word or an error appears on the master side in the cycle
// after the word that caused it is accepted. Header, flag and token high bytes
// give no data byte of their own. A token low byte is checked and issues the
// first history read; then the copy runs at one byte per cycle while the
// master side does not stall, for min(length, bytes still owed) bytes. The
// first copied byte passes through the history RAM read register and the
// output register. The copy rate is set by the single 4 KiB history RAM,
// which is read and written for every copied byte; a read of the byte being
// written in the same cycle is forwarded from the write data.
// The slave side is not ready while a copy runs. After reset the block waits
// for header byte 0; the history RAM is not cleared since a valid stream only
// reads bytes it has written. When the master side stalls, the output
// register holds its word and the block stops taking input or copying.
module lz77_type10_decompressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast    // final_res
);
    import lz77d_pkg::*;

    // History RAM with registered read data.
    logic [7:0]        r_mem [WINDOW_DEPTH];
    logic [7:0]        r_mem_q;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              r_fwd_vld;
    logic [7:0]        r_fwd_data;
    logic [7:0]        rd_data;

    // Parser state.
    t_phase            r_phase, n_phase;
    logic [1:0]        r_hdr_idx, n_hdr_idx;
    logic [SIZE_W-1:0] r_produced, n_produced;
    logic [SIZE_W-1:0] r_remain, n_remain;
    logic [7:0]        r_flag_bits, n_flag_bits;
    logic [3:0]        r_flags_left, n_flags_left;
    logic [7:0]        r_tok_hi, n_tok_hi;
    logic [ADDR_W-1:0] r_dist, n_dist;
    logic [COPY_W-1:0] r_copy_left, n_copy_left;
    logic              r_tok_last, n_tok_last;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_data, n_out_data;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    logic              in_acc;
    logic              out_free;
    logic              emit_vld;
    logic [7:0]        emit_data;
    t_status           emit_status;
    logic              emit_last;
    logic              do_adv;
    logic              adv_last;
    logic [ADDR_W-1:0] tok_dist;
    logic [COPY_W-1:0] tok_len;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_phase != PH_COPY) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    assign tok_dist = {r_tok_hi[3:0], s_axis_tdata};
    assign tok_len  = COPY_W'(r_tok_hi[7:4]) + COPY_W'(LEN_BIAS);
    assign rd_data  = r_fwd_vld ? r_fwd_data : r_mem_q;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_comb begin
        n_phase      = r_phase;
        n_hdr_idx    = r_hdr_idx;
        n_produced   = r_produced;
        n_remain     = r_remain;
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_tok_hi     = r_tok_hi;
        n_dist       = r_dist;
        n_copy_left  = r_copy_left;
        n_tok_last   = r_tok_last;
        n_out_valid  = out_free ? 1'b0 : r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        emit_vld     = 1'b0;
        emit_data    = 8'd0;
        emit_status  = ST_DATA;
        emit_last    = 1'b0;
        do_adv       = 1'b0;
        adv_last     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_produced[ADDR_W-1:0];
        wr_data      = s_axis_tdata;
        rd_addr      = r_produced[ADDR_W-1:0] - r_dist - ADDR_W'(1);

        case (r_phase)
            PH_FLAG: begin
                if (in_acc) begin
                    if (s_axis_tlast) begin
                        emit_vld    = 1'b1;
                        emit_status = ST_TRUNC;
                        emit_last   = 1'b1;
                        n_phase     = PH_HEADER;
                        n_hdr_idx   = 2'd0;
                    end else begin
                        n_flag_bits  = s_axis_tdata;
                        n_flags_left = 4'(FLAG_CNT);
                        n_phase      = s_axis_tdata[7] ? PH_TOKEN_HI : PH_LITERAL;
                    end
                end
            end
            PH_LITERAL: begin
                if (in_acc) begin
                    if (s_axis_tlast && r_remain > SIZE_W'(1)) begin
                        emit_vld    = 1'b1;
                        emit_status = ST_TRUNC;
                        emit_last   = 1'b1;
                        n_phase     = PH_HEADER;
                        n_hdr_idx   = 2'd0;
                    end else begin
                        wr_en      = 1'b1;
                        n_produced = r_produced + SIZE_W'(1);
                        n_remain   = r_remain - SIZE_W'(1);
                        emit_vld   = 1'b1;
                        emit_data  = s_axis_tdata;
                        emit_last  = (r_remain == SIZE_W'(1));
                        do_adv     = 1'b1;
                        adv_last   = s_axis_tlast;
                    end
                end
            end
            PH_TOKEN_HI: begin
                if (in_acc) begin
                    if (s_axis_tlast) begin
                        emit_vld    = 1'b1;
                        emit_status = ST_TRUNC;
                        emit_last   = 1'b1;
                        n_phase     = PH_HEADER;
                        n_hdr_idx   = 2'd0;
                    end else begin
                        n_tok_hi = s_axis_tdata;
                        n_phase  = PH_TOKEN_LO;
                    end
                end
            end
            PH_TOKEN_LO: begin
                rd_addr = r_produced[ADDR_W-1:0] - tok_dist - ADDR_W'(1);
                if (in_acc) begin
                    if (SIZE_W'(tok_dist) >= r_produced) begin
                        // The copy would reach back before the first byte.
                        emit_vld    = 1'b1;
                        emit_status = ST_DIST;
                        emit_last   = 1'b1;
                        n_phase     = s_axis_tlast ? PH_HEADER : PH_DRAIN;
                        n_hdr_idx   = 2'd0;
                    end else if (s_axis_tlast && SIZE_W'(tok_len) < r_remain) begin
                        emit_vld    = 1'b1;
                        emit_status = ST_TRUNC;
                        emit_last   = 1'b1;
                        n_phase     = PH_HEADER;
                        n_hdr_idx   = 2'd0;
                    end else begin
                        n_dist      = tok_dist;
                        n_copy_left = (r_remain < SIZE_W'(tok_len)) ?
                                      r_remain[COPY_W-1:0] : tok_len;
                        n_tok_last  = s_axis_tlast;
                        n_phase     = PH_COPY;
                    end
                end
            end
            PH_COPY: begin
                // The RAM output holds the source byte for the current position.
                if (out_free) begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data;
                    n_produced  = r_produced + SIZE_W'(1);
                    n_remain    = r_remain - SIZE_W'(1);
                    n_copy_left = r_copy_left - COPY_W'(1);
                    emit_vld    = 1'b1;
                    emit_data   = rd_data;
                    emit_last   = (r_remain == SIZE_W'(1));
                    rd_addr     = r_produced[ADDR_W-1:0] - r_dist;
                    if (r_copy_left == COPY_W'(1)) begin
                        do_adv   = 1'b1;
                        adv_last = r_tok_last;
                    end
                end
            end
            PH_DRAIN: begin
                if (in_acc && s_axis_tlast) begin
                    n_phase   = PH_HEADER;
                    n_hdr_idx = 2'd0;
                end
            end
            default: begin
                if (in_acc) begin
                    case (r_hdr_idx)
                        2'd1:    n_remain = SIZE_W'(s_axis_tdata);
                        2'd2:    n_remain[15:8] = s_axis_tdata;
                        2'd3:    n_remain[23:16] = s_axis_tdata;
                        default: n_remain = r_remain;
                    endcase
                    if (r_hdr_idx != 2'd3) begin
                        if (s_axis_tlast) begin
                            emit_vld    = 1'b1;
                            emit_status = ST_TRUNC;
                            emit_last   = 1'b1;
                            n_hdr_idx   = 2'd0;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 2'd1;
                        end
                        n_phase = PH_HEADER;
                    end else begin
                        n_hdr_idx    = 2'd0;
                        n_produced   = '0;
                        n_flag_bits  = 8'd0;
                        n_flags_left = 4'd0;
                        if (n_remain == '0) begin
                            // Empty stream: a single done word.
                            emit_vld  = 1'b1;
                            emit_last = 1'b1;
                            n_phase   = s_axis_tlast ? PH_HEADER : PH_DRAIN;
                        end else if (s_axis_tlast) begin
                            emit_vld    = 1'b1;
                            emit_status = ST_TRUNC;
                            emit_last   = 1'b1;
                            n_phase     = PH_HEADER;
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end
                end
            end
        endcase

        // Step to the next flag bit after a literal or a finished copy.
        if (do_adv) begin
            n_flag_bits  = {r_flag_bits[6:0], 1'b0};
            n_flags_left = (r_flags_left != 4'd0) ? r_flags_left - 4'd1 : 4'd0;
            if (n_remain == '0) begin
                n_phase   = adv_last ? PH_HEADER : PH_DRAIN;
                n_hdr_idx = 2'd0;
            end else if (n_flags_left == 4'd0) begin
                n_phase = PH_FLAG;
            end else begin
                n_phase = n_flag_bits[7] ? PH_TOKEN_HI : PH_LITERAL;
            end
        end

        if (emit_vld) begin
            n_out_valid  = 1'b1;
            n_out_data   = emit_data;
            n_out_status = emit_status;
            n_out_last   = emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_idx    <= 2'd0;
            r_produced   <= '0;
            r_remain     <= '0;
            r_flag_bits  <= 8'd0;
            r_flags_left <= 4'd0;
            r_tok_hi     <= 8'd0;
            r_copy_left  <= '0;
            r_tok_last   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fwd_vld    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_idx    <= n_hdr_idx;
            r_produced   <= n_produced;
            r_remain     <= n_remain;
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_tok_hi     <= n_tok_hi;
            r_copy_left  <= n_copy_left;
            r_tok_last   <= n_tok_last;
            r_out_valid  <= n_out_valid;
            r_fwd_vld    <= wr_en && (wr_addr == rd_addr);
        end
        r_dist       <= n_dist;
        r_fwd_data   <= wr_data;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // A running copy always has bytes left and never owes more than the stream.
    a_copy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COPY |-> r_copy_left != '0)
        else $error("copy running with nothing left");

    a_copy_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COPY |-> r_remain >= SIZE_W'(r_copy_left))
        else $error("copy runs past the stream size");

    a_body_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FLAG || r_phase == PH_LITERAL || r_phase == PH_TOKEN_HI ||
         r_phase == PH_TOKEN_LO) |-> r_remain != '0)
        else $error("parsing a stream body that is already complete");

    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_vld && emit_status != ST_DATA) |=>
        (r_phase == PH_HEADER || r_phase == PH_DRAIN) && r_hdr_idx == 2'd0)
        else $error("error word did not end the stream");

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_vld && emit_last) |=> (r_phase == PH_HEADER || r_phase == PH_DRAIN))
        else $error("final word did not end the stream");

endmodule
